// ===== src/xfsf_pkg.sv =====
// Package with constants and types shared by the xor filter slot and fingerprint pipeline.
`default_nettype none
package xfsf_pkg;
    localparam logic [63:0] C_GOLDEN_A = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [63:0] C_GOLDEN_B = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [63:0] C_MIX_M1   = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [63:0] C_MIX_M2   = 64'h94D0_49BB_1331_11EB;
    localparam int          C_SH1      = 30;
    localparam int          C_SH2      = 27;
    localparam int          C_SH3      = 31;
    localparam logic [30:0] C_SEG_MAX  = 31'h4000_0000;

    localparam logic [1:0] C_REG_SEGLEN = 2'd0;
    localparam logic [1:0] C_REG_SEED   = 2'd1;
    localparam logic [1:0] C_REG_FPW    = 2'd2;

    // 64x64 low product cut into partial products of the 32-bit halves.
    typedef struct packed {
        logic [63:0] ll;
        logic [31:0] lh;
        logic [31:0] hl;
    } t_pp;
endpackage
`default_nettype wire

// ===== src/xor_filter_slot_and_fingerprint.sv =====
// Top level of the xor filter slot and fingerprint pipeline.
`default_nettype none
// This block turns one 64-bit key hash per clock into the three slot indices of a
// three-segment xor filter and a nonzero fingerprint. A request is taken at every
// rising edge with i_start high and o_busy low; o_busy is always low, so a new key
// may be issued in every cycle. Each request yields exactly one result, shown for one
// cycle with o_done high: a register forms the seeded sums, the SplitMix64 finalizer
// follows (two split 64-bit multipliers of two stages each), and then the modulo
// units load the dividend, retire one quotient bit per stage and finish with an
// offset add. The receiver cannot stall, so results must be consumed as they appear.
// Configuration is to be written by the user through i_cfg_we only while no request
// is in flight; the block itself does not enforce it. A segment length of zero acts
// as one and one above 2^30 is clamped, and a fingerprint width of 32 or more keeps
// all bits.
module xor_filter_slot_and_fingerprint (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_start,
    output logic        o_busy,
    input  wire  [63:0] i_key_hash,
    input  wire         i_cfg_we,
    input  wire  [1:0]  i_cfg_index,
    input  wire  [63:0] i_cfg_data,
    output logic        o_done,
    output logic [29:0] o_slot_first,
    output logic [30:0] o_slot_second,
    output logic [31:0] o_slot_third,
    output logic [31:0] o_fingerprint
);
    localparam int LP_MIX = 7;
    localparam int LP_MOD = 34;
    localparam int LP_LAT = 1 + LP_MIX + LP_MOD;

    logic [30:0] r_seg_len;
    logic [63:0] r_seed;
    logic [5:0]  r_fpw;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg_len <= 31'd1;
            r_seed    <= 64'd0;
            r_fpw     <= 6'd8;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                xfsf_pkg::C_REG_SEGLEN: r_seg_len <= i_cfg_data[30:0];
                xfsf_pkg::C_REG_SEED:   r_seed    <= i_cfg_data;
                xfsf_pkg::C_REG_FPW:    r_fpw     <= i_cfg_data[5:0];
                default: ;
            endcase
        end
    end

    // Clamped length and mask; the user keeps them stable while requests are in flight.
    logic [30:0] w_len;
    logic [31:0] w_mask;
    assign w_len = (r_seg_len == 31'd0) ? 31'd1 :
                   (r_seg_len > xfsf_pkg::C_SEG_MAX) ? xfsf_pkg::C_SEG_MAX : r_seg_len;
    assign w_mask = (r_fpw >= 6'd32) ? 32'hFFFF_FFFF :
                    ((32'd1 << r_fpw[4:0]) - 32'd1);

    logic        w_acc;
    logic [63:0] r_sa;
    logic [63:0] r_sb;
    assign w_acc  = i_start && !o_busy;
    assign o_busy = 1'b0;

    // Seeded sums; the seed add and the constant add are registered together.
    always_ff @(posedge i_clk) begin
        r_sa <= i_key_hash + r_seed + xfsf_pkg::C_GOLDEN_A;
        r_sb <= i_key_hash + r_seed + xfsf_pkg::C_GOLDEN_B;
    end

    logic [63:0] w_m0;
    logic [63:0] w_m1;
    xfsf_mixer u_mix0 (.i_clk(i_clk), .i_v(r_sa), .o_m(w_m0));
    xfsf_mixer u_mix1 (.i_clk(i_clk), .i_v(r_sb), .o_m(w_m1));

    // Mixer output, after the seeded sums and the mixer pipeline, feeds the modulo units.
    logic [31:0] w_r0;
    logic [31:0] w_r1;
    logic [31:0] w_r2;
    xfsf_mod32 u_mod0 (.i_clk(i_clk), .i_num(w_m0[31:0]),  .i_len(w_len),
                       .i_off(32'd0), .o_res(w_r0));
    xfsf_mod32 u_mod1 (.i_clk(i_clk), .i_num(w_m0[63:32]), .i_len(w_len),
                       .i_off({1'b0, w_len}), .o_res(w_r1));
    xfsf_mod32 u_mod2 (.i_clk(i_clk), .i_num(w_m1[31:0]),  .i_len(w_len),
                       .i_off({w_len, 1'b0}), .o_res(w_r2));

    // Fingerprint is finished early and delayed alongside the slots.
    logic [31:0] w_fp;
    logic [31:0] r_fp [0:LP_MOD-1];
    assign w_fp = ((w_m1[63:32] & w_mask) == 32'd0) ? 32'd1 : (w_m1[63:32] & w_mask);

    always_ff @(posedge i_clk) begin
        r_fp[0] <= w_fp;
        for (int k = 1; k < LP_MOD; k++) begin
            r_fp[k] <= r_fp[k-1];
        end
    end

    // Valid bits travel down the pipeline with the data.
    logic [LP_LAT-1:0] r_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LP_LAT-2:0], w_acc};
        end
    end

    assign o_done        = r_vld[LP_LAT-1];
    assign o_slot_first  = w_r0[29:0];
    assign o_slot_second = w_r1[30:0];
    assign o_slot_third  = w_r2;
    assign o_fingerprint = r_fp[LP_MOD-1];

`ifndef SYNTH
    a_fp_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_fingerprint != 32'd0))
        else $error("fingerprint is zero");
    a_first_lt_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ({1'b0, o_slot_first} < w_len))
        else $error("first slot out of segment");
    a_second_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_slot_second >= w_len))
        else $error("second slot below its segment");
    a_done_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> r_vld[LP_LAT-2] == $past(r_vld[LP_LAT-3]))
        else $error("valid chain broken");
`endif
endmodule
`default_nettype wire

// ===== src/xfsf_mul64.sv =====
// Two-stage 64-bit multiply by a constant, keeping the low 64 bits of the product.
`default_nettype none
module xfsf_mul64 #(
    parameter logic [63:0] P_K = 64'h1
) (
    input  wire         i_clk,
    input  wire  [63:0] i_a,
    output logic [63:0] o_p
);
    xfsf_pkg::t_pp r_pp;
    xfsf_pkg::t_pp n_pp;
    logic [63:0]   r_p;

    always_comb begin
        n_pp.ll = {32'd0, i_a[31:0]} * {32'd0, P_K[31:0]};
        n_pp.lh = i_a[31:0] * P_K[63:32];
        n_pp.hl = i_a[63:32] * P_K[31:0];
    end

    always_ff @(posedge i_clk) begin
        r_pp <= n_pp;
        r_p  <= r_pp.ll + {r_pp.lh + r_pp.hl, 32'd0};
    end

    assign o_p = r_p;
endmodule
`default_nettype wire

// ===== src/xfsf_mod32.sv =====
// Pipelined 32-bit modulo by a segment length, one quotient bit per stage, plus offset.
`default_nettype none
module xfsf_mod32 (
    input  wire         i_clk,
    input  wire  [31:0] i_num,
    input  wire  [30:0] i_len,
    input  wire  [31:0] i_off,
    output logic [31:0] o_res
);
    // Stage k handles dividend bit 31-k with a restoring step.
    logic [31:0] r_rem [0:32];
    logic [31:0] r_num [0:32];
    logic [30:0] r_len [0:32];
    logic [31:0] r_off [0:32];
    logic [31:0] r_out;

    always_ff @(posedge i_clk) begin
        r_rem[0] <= 32'd0;
        r_num[0] <= i_num;
        r_len[0] <= i_len;
        r_off[0] <= i_off;
        r_out    <= r_rem[32] + r_off[32];
    end

    genvar g;
    generate
        for (g = 0; g < 32; g++) begin : g_step
            logic [32:0] w_t;
            logic [32:0] w_d;
            assign w_t = {r_rem[g], r_num[g][31 - g]};
            assign w_d = w_t - {2'd0, r_len[g]};
            always_ff @(posedge i_clk) begin
                r_rem[g+1] <= w_d[32] ? w_t[31:0] : w_d[31:0];
                r_num[g+1] <= r_num[g];
                r_len[g+1] <= r_len[g];
                r_off[g+1] <= r_off[g];
            end
        end
    endgenerate

    assign o_res = r_out;
endmodule
`default_nettype wire

// ===== src/xfsf_mixer.sv =====
// SplitMix64 finalizer as a pipeline: xor-shift, multiply, xor-shift, multiply, xor-shift.
`default_nettype none
module xfsf_mixer (
    input  wire         i_clk,
    input  wire  [63:0] i_v,
    output logic [63:0] o_m
);
    logic [63:0] r_a;
    logic [63:0] w_p1;
    logic [63:0] r_b;
    logic [63:0] w_p2;
    logic [63:0] r_c;

    always_ff @(posedge i_clk) begin
        r_a <= i_v ^ (i_v >> xfsf_pkg::C_SH1);
        r_b <= w_p1 ^ (w_p1 >> xfsf_pkg::C_SH2);
        r_c <= w_p2 ^ (w_p2 >> xfsf_pkg::C_SH3);
    end

    xfsf_mul64 #(.P_K(xfsf_pkg::C_MIX_M1)) u_m1 (.i_clk(i_clk), .i_a(r_a), .o_p(w_p1));
    xfsf_mul64 #(.P_K(xfsf_pkg::C_MIX_M2)) u_m2 (.i_clk(i_clk), .i_a(r_b), .o_p(w_p2));

    assign o_m = r_c;
endmodule
`default_nettype wire

// ===== verif/xor_filter_slot_and_fingerprint_checker.sv =====
// Checker that predicts the slot indices and fingerprint of each request and compares results.
`timescale 1ns / 100ps
`default_nettype none
module xor_filter_slot_and_fingerprint_checker (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_start,
    input  wire         i_busy,
    input  wire  [63:0] i_key_hash,
    input  wire         i_cfg_we,
    input  wire  [1:0]  i_cfg_index,
    input  wire  [63:0] i_cfg_data,
    input  wire         i_done,
    input  wire  [29:0] i_slot_first,
    input  wire  [30:0] i_slot_second,
    input  wire  [31:0] i_slot_third,
    input  wire  [31:0] i_fingerprint,
    output int          o_fail_count,
    output int          o_pending
);
    typedef struct packed {
        logic [29:0] slot_first;
        logic [30:0] slot_second;
        logic [31:0] slot_third;
        logic [31:0] fingerprint;
    } t_slots;

    t_slots      slots_q[$];
    logic [30:0] seg_len;
    logic [63:0] seed;
    logic [5:0]  fp_width;

    function automatic logic [63:0] splitmix(input logic [63:0] v);
        logic [63:0] x;
        x = (v ^ (v >> 30)) * 64'hBF58_476D_1CE4_E5B9;
        x = (x ^ (x >> 27)) * 64'h94D0_49BB_1331_11EB;
        return x ^ (x >> 31);
    endfunction

    function automatic t_slots place_key(input logic [63:0] key);
        t_slots      r;
        logic [63:0] base;
        logic [63:0] m0;
        logic [63:0] m1;
        logic [63:0] len;
        logic [63:0] mask;
        logic [63:0] fp;
        base = key + seed;
        m0 = splitmix(base + 64'h9E37_79B9_7F4A_7C15);
        m1 = splitmix(base + 64'hBF58_476D_1CE4_E5B9);
        len = {33'd0, seg_len};
        if (len == 0) len = 1;
        if (len > 64'h4000_0000) len = 64'h4000_0000;
        mask = (fp_width >= 32) ? 64'hFFFF_FFFF : ((64'd1 << fp_width) - 1);
        fp = (m1 >> 32) & mask;
        if (fp == 0) fp = 1;
        r.slot_first  = 30'({32'd0, m0[31:0]} % len);
        r.slot_second = 31'(({32'd0, m0[63:32]} % len) + len);
        r.slot_third  = 32'(({32'd0, m1[31:0]} % len) + 2 * len);
        r.fingerprint = fp[31:0];
        return r;
    endfunction

    assign o_pending = slots_q.size();

    always @(posedge i_clk) begin
        t_slots e;
        if (!i_rst_n) begin
            seg_len <= 31'd1;
            seed <= 64'd0;
            fp_width <= 6'd8;
            o_fail_count <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    xfsf_pkg::C_REG_SEGLEN: seg_len <= i_cfg_data[30:0];
                    xfsf_pkg::C_REG_SEED: seed <= i_cfg_data;
                    xfsf_pkg::C_REG_FPW: fp_width <= i_cfg_data[5:0];
                    default: ;
                endcase
            end
            if (i_start && !i_busy) slots_q.push_back(place_key(i_key_hash));
            if (i_done) begin
                if (slots_q.size() == 0) begin
                    if (o_fail_count < 10) $display("Unexpected result at %0t", $realtime);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    e = slots_q.pop_front();
                    if (e != {i_slot_first, i_slot_second, i_slot_third, i_fingerprint}) begin
                        if (o_fail_count < 10)
                            $display("Mismatch: exp %h %h %h %h got %h %h %h %h",
                                e.slot_first, e.slot_second, e.slot_third, e.fingerprint,
                                i_slot_first, i_slot_second, i_slot_third, i_fingerprint);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule
`default_nettype wire

// ===== verif/xor_filter_slot_and_fingerprint_tb.sv =====
// Testbench top that drives key hash requests and configuration and reports the verdict.
`timescale 1ns / 100ps
`default_nettype none
module xor_filter_slot_and_fingerprint_tb;
    // A margin beyond the pipeline latency covers the drain at the end.
    localparam int C_DRAIN = 60;
    localparam int C_LIMIT = 400000;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic [63:0] key_hash;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;
    wire         busy;
    wire         done;
    wire  [29:0] slot_first;
    wire  [30:0] slot_second;
    wire  [31:0] slot_third;
    wire  [31:0] fingerprint;
    int          fail_count;
    int          pending;
    int          cycles;
    int          idle_pct;

    xor_filter_slot_and_fingerprint dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_start(start), .o_busy(busy),
        .i_key_hash(key_hash), .i_cfg_we(cfg_we), .i_cfg_index(cfg_index),
        .i_cfg_data(cfg_data), .o_done(done), .o_slot_first(slot_first),
        .o_slot_second(slot_second), .o_slot_third(slot_third),
        .o_fingerprint(fingerprint)
    );

    xor_filter_slot_and_fingerprint_checker checker_inst (
        .i_clk(clk), .i_rst_n(rst_n), .i_start(start), .i_busy(busy),
        .i_key_hash(key_hash), .i_cfg_we(cfg_we), .i_cfg_index(cfg_index),
        .i_cfg_data(cfg_data), .i_done(done), .i_slot_first(slot_first),
        .i_slot_second(slot_second), .i_slot_third(slot_third),
        .i_fingerprint(fingerprint), .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // The watchdog ends a run that hangs.
    initial begin
        cycles = 0;
        forever begin
            @(posedge clk);
            cycles++;
            if (cycles > C_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // One request is presented at a falling edge and held until it is taken.
    task automatic send_request(input logic [63:0] key);
        start <= 1'b1;
        key_hash <= key;
        @(posedge clk);
        while (busy) @(posedge clk);
        @(negedge clk);
        // Each following cycle is idle with the given chance; start stays high if none.
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            key_hash <= {$urandom, $urandom};
            @(negedge clk);
        end
    endtask

    // Waits until every request has its result, plus a drain margin.
    task automatic drain_results();
        start <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (C_DRAIN) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        cfg_data <= {$urandom, $urandom};
    endtask

    // Random segment lengths favor small values, with the extremes sometimes.
    function automatic logic [63:0] pick_seglen();
        case ($urandom_range(5))
            0: return 64'd1;
            1: return 64'h4000_0000;
            2: return {32'd0, $urandom_range(2147483647, 1073741825)};
            3: return {$urandom, $urandom};
            default: return 64'($urandom_range(1000, 0));
        endcase
    endfunction

    initial begin
        logic [63:0] key;
        rst_n = 1'b0;
        start = 1'b0;
        key_hash = '0;
        cfg_we = 1'b0;
        cfg_index = xfsf_pkg::C_REG_SEGLEN;
        cfg_data = '0;
        idle_pct = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed requests under the reset settings, then at the extremes.
        send_request(64'd0);
        send_request('1);
        send_request(64'h8000_0000_0000_0000);
        send_request(64'd1);
        drain_results();
        write_reg(xfsf_pkg::C_REG_SEGLEN, 64'd0);
        write_reg(xfsf_pkg::C_REG_FPW, 64'd0);
        write_reg(xfsf_pkg::C_REG_SEED, '1);
        send_request(64'h1234_5678_9ABC_DEF0);
        send_request('1);
        drain_results();
        write_reg(xfsf_pkg::C_REG_SEGLEN, 64'h4000_0000);
        write_reg(xfsf_pkg::C_REG_FPW, 64'd32);
        write_reg(xfsf_pkg::C_REG_SEED, 64'd0);
        send_request(64'hFFFF_FFFF_0000_0000);
        send_request(64'h0000_0000_FFFF_FFFF);
        drain_results();
        write_reg(xfsf_pkg::C_REG_SEGLEN, 64'h7FFF_FFFF);
        write_reg(xfsf_pkg::C_REG_FPW, 64'd63);
        send_request(64'hDEAD_BEEF_CAFE_F00D);
        send_request(64'h5555_5555_5555_5555);
        drain_results();
        write_reg(xfsf_pkg::C_REG_SEGLEN, 64'd3);
        write_reg(xfsf_pkg::C_REG_FPW, 64'd1);
        for (int i = 0; i < 8; i++) send_request(64'(i));
        drain_results();

        // Random phases cycle through idle levels and register settings.
        for (int phase = 0; phase < 12; phase++) begin
            case (phase % 4)
                0: idle_pct = 0;
                1: idle_pct = 63;
                2: idle_pct = 13;
                default: idle_pct = 63;
            endcase
            write_reg(xfsf_pkg::C_REG_SEGLEN, pick_seglen());
            write_reg(xfsf_pkg::C_REG_SEED, {$urandom, $urandom});
            write_reg(xfsf_pkg::C_REG_FPW, 64'($urandom_range(63, 0)));
            for (int n = 0; n < 100; n++) begin
                key = {$urandom, $urandom};
                send_request(key);
            end
            drain_results();
        end

        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== xor_filter_slot_and_fingerprint.f =====
src/xfsf_pkg.sv
src/xfsf_mul64.sv
src/xfsf_mod32.sv
src/xfsf_mixer.sv
src/xor_filter_slot_and_fingerprint.sv
verif/xor_filter_slot_and_fingerprint_checker.sv
verif/xor_filter_slot_and_fingerprint_tb.sv
